FILE: sv/charge_division_position_filter_assert.svh
// ---------------------------------------------------------------------------
// charge division position filter - assertion macros
// concurrent checks clocked on clk and disabled while arst_n is low
// ---------------------------------------------------------------------------
`ifndef CHARGE_DIVISION_POSITION_FILTER_ASSERT_SVH
`define CHARGE_DIVISION_POSITION_FILTER_ASSERT_SVH

// same-cycle implication
`define CDPF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CDPF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/cdpf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cdpf_pkg
// widths, constants and controller/datapath types of the position filter
// ---------------------------------------------------------------------------
package cdpf_pkg;

	localparam int DET_W    = 4;
	localparam int CHARGE_W = 12;
	localparam int SUM_W    = CHARGE_W + 1;
	localparam int RATIO_W  = 16;
	localparam int QUO_W    = RATIO_W - 1;
	localparam int MULT_W   = 5;
	localparam int DIV_STEPS = QUO_W;
	localparam int ITER_W   = $clog2(DIV_STEPS);

	localparam int NUM_DETECTORS_DEF = 16;
	localparam int COUNT_FIELD_MAX   = 31;
	localparam logic [CHARGE_W-1:0] THRESHOLD_RESET = 12'd400;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_HOLD = 3'b100
	} cdpf_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic emit;
		logic cfg_wr;
	} cdpf_cmd_t;

	typedef struct packed {
		logic div_last;
	} cdpf_sts_t;

endpackage

FILE: sv/cdpf_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cdpf_in_if
// detector item channel: four charges, index and end-of-event mark
// ---------------------------------------------------------------------------
interface cdpf_in_if;
	logic                              valid;
	logic                              ready;
	logic [cdpf_pkg::DET_W-1:0]        detector_index;
	logic [cdpf_pkg::CHARGE_W-1:0]     charge_x_first;
	logic [cdpf_pkg::CHARGE_W-1:0]     charge_x_second;
	logic [cdpf_pkg::CHARGE_W-1:0]     charge_z_first;
	logic [cdpf_pkg::CHARGE_W-1:0]     charge_z_second;
	logic                              event_last;

	modport source (
		output valid, detector_index, charge_x_first, charge_x_second,
		       charge_z_first, charge_z_second, event_last,
		input  ready
	);
	modport sink (
		input  valid, detector_index, charge_x_first, charge_x_second,
		       charge_z_first, charge_z_second, event_last,
		output ready
	);
endinterface

FILE: sv/cdpf_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cdpf_out_if
// result channel: ratios, acceptance and event multiplicity
// ---------------------------------------------------------------------------
interface cdpf_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [cdpf_pkg::DET_W-1:0]           detector_out;
	logic                                 accepted;
	logic signed [cdpf_pkg::RATIO_W-1:0]  x_ratio;
	logic signed [cdpf_pkg::RATIO_W-1:0]  z_ratio;
	logic                                 event_done;
	logic [cdpf_pkg::MULT_W-1:0]          multiplicity;

	modport source (
		output valid, detector_out, accepted, x_ratio, z_ratio, event_done, multiplicity,
		input  ready
	);
	modport sink (
		input  valid, detector_out, accepted, x_ratio, z_ratio, event_done, multiplicity,
		output ready
	);
endinterface

FILE: sv/cdpf_cfg_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cdpf_cfg_if
// threshold register write channel
// ---------------------------------------------------------------------------
interface cdpf_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [cdpf_pkg::CHARGE_W-1:0] charge_threshold;

	modport source (output valid, charge_threshold, input ready);
	modport sink   (input valid, charge_threshold, output ready);
endinterface

FILE: sv/cdpf_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cdpf_datapath
// threshold test, two radix-2 restoring divider lanes, event counter and
// result register
// ---------------------------------------------------------------------------
module cdpf_datapath #(
	parameter int NUM_DETECTORS = cdpf_pkg::NUM_DETECTORS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cdpf_pkg::cdpf_cmd_t                 cmd,
	output cdpf_pkg::cdpf_sts_t                 sts,
	input  logic [cdpf_pkg::CHARGE_W-1:0]       cfg_data,
	input  logic [cdpf_pkg::DET_W-1:0]          detector_index,
	input  logic [cdpf_pkg::CHARGE_W-1:0]       charge_x_first,
	input  logic [cdpf_pkg::CHARGE_W-1:0]       charge_x_second,
	input  logic [cdpf_pkg::CHARGE_W-1:0]       charge_z_first,
	input  logic [cdpf_pkg::CHARGE_W-1:0]       charge_z_second,
	input  logic                                event_last,
	output logic [cdpf_pkg::DET_W-1:0]          detector_out,
	output logic                                accepted,
	output logic signed [cdpf_pkg::RATIO_W-1:0] x_ratio,
	output logic signed [cdpf_pkg::RATIO_W-1:0] z_ratio,
	output logic                                event_done,
	output logic [cdpf_pkg::MULT_W-1:0]         multiplicity
);

	localparam int CW = cdpf_pkg::CHARGE_W;
	localparam int SW = cdpf_pkg::SUM_W;
	localparam int QW = cdpf_pkg::QUO_W;
	localparam int RW = cdpf_pkg::RATIO_W;
	localparam int MW = cdpf_pkg::MULT_W;
	localparam int IW = cdpf_pkg::ITER_W;
	localparam int COUNT_LIMIT = (NUM_DETECTORS < cdpf_pkg::COUNT_FIELD_MAX) ?
		NUM_DETECTORS : cdpf_pkg::COUNT_FIELD_MAX;

	logic [CW-1:0] thr_q;
	logic [MW-1:0] count_q;
	logic [IW-1:0] iter_q;

	logic [cdpf_pkg::DET_W-1:0] det_q;
	logic                       ok_q;
	logic                       last_q;
	logic [MW-1:0]              mult_q;
	logic [SW-1:0]              sum_q [2];
	logic [SW-1:0]              rem_q [2];
	logic [QW-1:0]              quo_q [2];
	logic                       neg_q [2];

	logic [CW-1:0] first_c  [2];
	logic [CW-1:0] second_c [2];
	logic [SW-1:0] sum_c    [2];
	logic [CW-1:0] diff_c   [2];
	logic          neg_c    [2];
	logic [SW:0]   rem_sh   [2];
	logic          fits     [2];
	logic [SW-1:0] rem_nx   [2];
	logic [RW-1:0] ratio_c  [2];

	logic          ok_c;
	logic          inc_c;
	logic [MW-1:0] count_inc;

	assign first_c[0]  = charge_x_first;
	assign second_c[0] = charge_x_second;
	assign first_c[1]  = charge_z_first;
	assign second_c[1] = charge_z_second;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			sum_c[i]  = {1'b0, first_c[i]} + {1'b0, second_c[i]};
			neg_c[i]  = second_c[i] < first_c[i];
			diff_c[i] = neg_c[i] ? (first_c[i] - second_c[i]) : (second_c[i] - first_c[i]);
			rem_sh[i] = {rem_q[i], 1'b0};
			fits[i]   = rem_sh[i] >= {1'b0, sum_q[i]};
			rem_nx[i] = fits[i] ? SW'(rem_sh[i] - {1'b0, sum_q[i]}) : rem_sh[i][SW-1:0];
			if (!ok_q) begin
				ratio_c[i] = '0;
			end else if (neg_q[i]) begin
				ratio_c[i] = RW'(-{1'b0, quo_q[i]});
			end else begin
				ratio_c[i] = {1'b0, quo_q[i]};
			end
		end
	end

	assign ok_c = (charge_x_first > thr_q) && (charge_x_second > thr_q) &&
		(charge_z_first > thr_q) && (charge_z_second > thr_q);
	assign inc_c     = ok_c && (count_q < MW'(COUNT_LIMIT));
	assign count_inc = inc_c ? MW'(count_q + 1'b1) : count_q;

	assign sts.div_last = (iter_q == IW'(cdpf_pkg::DIV_STEPS - 1));

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= cdpf_pkg::THRESHOLD_RESET;
			count_q <= '0;
			iter_q  <= '0;
		end else begin
			if (cmd.cfg_wr) begin
				thr_q <= cfg_data;
			end
			if (cmd.load) begin
				count_q <= event_last ? '0 : count_inc;
				iter_q  <= '0;
			end else if (cmd.step) begin
				iter_q <= IW'(iter_q + 1'b1);
			end
		end
	end

	// operands and divider lanes
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			det_q  <= detector_index;
			ok_q   <= ok_c;
			last_q <= event_last;
			mult_q <= event_last ? count_inc : '0;
			for (int i = 0; i < 2; i++) begin
				sum_q[i] <= sum_c[i];
				rem_q[i] <= {1'b0, diff_c[i]};
				quo_q[i] <= '0;
				neg_q[i] <= neg_c[i];
			end
		end else if (cmd.step) begin
			for (int i = 0; i < 2; i++) begin
				rem_q[i] <= rem_nx[i];
				quo_q[i] <= {quo_q[i][QW-2:0], fits[i]};
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			detector_out <= det_q;
			accepted     <= ok_q;
			x_ratio      <= ratio_c[0];
			z_ratio      <= ratio_c[1];
			event_done   <= last_q;
			multiplicity <= mult_q;
		end
	end

endmodule

FILE: sv/cdpf_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cdpf_ctrl
// sequencer for load, divide and result hand-off; owns the result valid
// ---------------------------------------------------------------------------
module cdpf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	output cdpf_pkg::cdpf_cmd_t cmd,
	input  cdpf_pkg::cdpf_sts_t sts
);

	cdpf_pkg::cdpf_state_t state_q;
	cdpf_pkg::cdpf_state_t state_nx;
	logic                  out_valid_q;
	logic                  out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == cdpf_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;

	always_comb begin
		state_nx   = state_q;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.emit   = 1'b0;
		cmd.cfg_wr = cfg_valid;
		case (state_q)
			cdpf_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = cdpf_pkg::S_DIV;
				end
			end
			cdpf_pkg::S_DIV: begin
				cmd.step = 1'b1;
				if (sts.div_last) begin
					state_nx = cdpf_pkg::S_HOLD;
				end
			end
			cdpf_pkg::S_HOLD: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_nx = cdpf_pkg::S_IDLE;
				end
			end
			default: begin
				state_nx = cdpf_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cdpf_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: sv/charge_division_position_filter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// charge_division_position_filter
// per-detector threshold test, X/Z charge-division ratios in Q1.15 and
// accepted-detector multiplicity per event
//
// det_in carries one detector item (four charges, index, end-of-event mark);
// res_out gives exactly one result item per detector item, in order.
// cfg writes the 12-bit charge threshold; it is always ready.
// after acceptance an item runs the 15 divider iterations, then its hand-off
// to the result register raises res_out.valid.
// a new item is taken only once the 15 iterations of the two radix-2 divider
// lanes that work X and Z side by side and the hand-off have finished.
// the result register lets the next item enter while a result is waiting;
// if res_out stays stalled the finished item holds in the datapath and
// det_in.ready stays low until the result register frees.
// reset: threshold back to 400, event count cleared, no result pending.
// ---------------------------------------------------------------------------
module charge_division_position_filter #(
	parameter int NUM_DETECTORS = cdpf_pkg::NUM_DETECTORS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	cdpf_in_if.sink     det_in,
	cdpf_out_if.source  res_out,
	cdpf_cfg_if.sink    cfg
);

	cdpf_pkg::cdpf_cmd_t cmd;
	cdpf_pkg::cdpf_sts_t sts;

	cdpf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (det_in.valid),
		.in_ready  (det_in.ready),
		.out_valid (res_out.valid),
		.out_ready (res_out.ready),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	cdpf_datapath #(
		.NUM_DETECTORS (NUM_DETECTORS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_data        (cfg.charge_threshold),
		.detector_index  (det_in.detector_index),
		.charge_x_first  (det_in.charge_x_first),
		.charge_x_second (det_in.charge_x_second),
		.charge_z_first  (det_in.charge_z_first),
		.charge_z_second (det_in.charge_z_second),
		.event_last      (det_in.event_last),
		.detector_out    (res_out.detector_out),
		.accepted        (res_out.accepted),
		.x_ratio         (res_out.x_ratio),
		.z_ratio         (res_out.z_ratio),
		.event_done      (res_out.event_done),
		.multiplicity    (res_out.multiplicity)
	);

endmodule

FILE: sv/cdpf_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cdpf_port_checks
// port-level checks on the position filter, bound to the top level
// ---------------------------------------------------------------------------
`include "charge_division_position_filter_assert.svh"

module cdpf_port_checks (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic                                accepted,
	input logic signed [cdpf_pkg::RATIO_W-1:0] x_ratio,
	input logic signed [cdpf_pkg::RATIO_W-1:0] z_ratio,
	input logic                                event_done,
	input logic [cdpf_pkg::MULT_W-1:0]         multiplicity
);

	`CDPF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

	`CDPF_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken during work")

	`CDPF_ASSERT_SAME(a_reject_zero, out_valid && !accepted, (x_ratio == 0) && (z_ratio == 0), "rejected item has ratio")

	`CDPF_ASSERT_SAME(a_mult_idle, out_valid && !event_done, multiplicity == 0, "multiplicity off event end")

endmodule

bind charge_division_position_filter cdpf_port_checks u_cdpf_port_checks (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (det_in.valid),
	.in_ready     (det_in.ready),
	.out_valid    (res_out.valid),
	.out_ready    (res_out.ready),
	.accepted     (res_out.accepted),
	.x_ratio      (res_out.x_ratio),
	.z_ratio      (res_out.z_ratio),
	.event_done   (res_out.event_done),
	.multiplicity (res_out.multiplicity)
);

FILE: dv/cdpf_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cdpf_checker
// watches the detector, result and threshold channels of the position
// filter, predicts one result per detector item from its own copy
// of the threshold and the event count, and compares every result item
// field by field with the oldest prediction still waiting
// ---------------------------------------------------------------------------
module cdpf_checker #(
	parameter int NUM_DETECTORS = cdpf_pkg::NUM_DETECTORS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	cdpf_in_if   det,
	cdpf_out_if  res,
	cdpf_cfg_if  cfg,
	output int   failures,
	output int   outstanding,
	output int   results_seen,
	output int   accepted_seen
);

	localparam int COUNT_LIMIT = NUM_DETECTORS < cdpf_pkg::COUNT_FIELD_MAX ?
		NUM_DETECTORS : cdpf_pkg::COUNT_FIELD_MAX;

	typedef struct packed {
		logic [cdpf_pkg::DET_W-1:0]          det;
		logic                                accepted;
		logic signed [cdpf_pkg::RATIO_W-1:0] x_ratio;
		logic signed [cdpf_pkg::RATIO_W-1:0] z_ratio;
		logic                                event_done;
		logic [cdpf_pkg::MULT_W-1:0]         multiplicity;
	} position_result_t;

	position_result_t              positions_due[$];
	position_result_t              want;
	logic [cdpf_pkg::CHARGE_W-1:0] threshold;
	logic [cdpf_pkg::MULT_W-1:0]   event_count;

	// (second - first) / (first + second) in Q1.15, truncated toward zero
	function automatic logic signed [cdpf_pkg::RATIO_W-1:0] division_q15(
		input logic [cdpf_pkg::CHARGE_W-1:0] first,
		input logic [cdpf_pkg::CHARGE_W-1:0] second
	);
		int unsigned sum;
		int unsigned diff;
		int unsigned mag;
		sum = first + second;
		if (sum == 0) begin
			return '0;
		end
		diff = (second >= first) ? second - first : first - second;
		mag = diff * 32'd32768 / sum;
		if (mag > 32767) begin
			mag = 32767;
		end
		division_q15 = cdpf_pkg::RATIO_W'(mag);
		if (second < first) begin
			division_q15 = -division_q15;
		end
	endfunction

	function automatic position_result_t predict_position(
		input logic [cdpf_pkg::DET_W-1:0]    idx,
		input logic [cdpf_pkg::CHARGE_W-1:0] x1,
		input logic [cdpf_pkg::CHARGE_W-1:0] x2,
		input logic [cdpf_pkg::CHARGE_W-1:0] z1,
		input logic [cdpf_pkg::CHARGE_W-1:0] z2,
		input logic                          last
	);
		position_result_t r;
		r = '0;
		r.det = idx;
		r.accepted = (x1 > threshold) && (x2 > threshold) &&
			(z1 > threshold) && (z2 > threshold);
		if (r.accepted) begin
			r.x_ratio = division_q15(x1, x2);
			r.z_ratio = division_q15(z1, z2);
			if (event_count < COUNT_LIMIT) begin
				event_count = event_count + 1'b1;
			end
		end
		r.event_done = last;
		if (last) begin
			r.multiplicity = event_count;
			event_count = '0;
		end
		return r;
	endfunction

	function automatic void check_field(
		input string              name,
		input logic signed [31:0] expected_value,
		input logic signed [31:0] actual_value
	);
		if (actual_value !== expected_value) begin
			failures++;
			$error("%s: expected %0d, got %0d", name, expected_value, actual_value);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			positions_due.delete();
			threshold = cdpf_pkg::THRESHOLD_RESET;
			event_count = '0;
			failures = 0;
			results_seen = 0;
			accepted_seen = 0;
		end else begin
			if (det.valid && det.ready) begin
				positions_due.push_back(predict_position(det.detector_index,
					det.charge_x_first, det.charge_x_second,
					det.charge_z_first, det.charge_z_second, det.event_last));
			end
			if (res.valid && res.ready) begin
				results_seen++;
				if (res.accepted === 1'b1) begin
					accepted_seen++;
				end
				if (positions_due.size() == 0) begin
					failures++;
					$error("result item with no expected result waiting");
				end else begin
					want = positions_due.pop_front();
					check_field("detector_out", want.det, res.detector_out);
					check_field("accepted", want.accepted, res.accepted);
					check_field("x_ratio", $signed(want.x_ratio), $signed(res.x_ratio));
					check_field("z_ratio", $signed(want.z_ratio), $signed(res.z_ratio));
					check_field("event_done", want.event_done, res.event_done);
					check_field("multiplicity", want.multiplicity, res.multiplicity);
				end
			end
			if (cfg.valid && cfg.ready) begin
				threshold = cfg.charge_threshold;
			end
		end
		outstanding = positions_due.size();
	end

endmodule

FILE: dv/charge_division_position_filter_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// charge_division_position_filter_tb
// drives detector items and threshold writes into the position filter with
// random idling on both channels; a directed set covers threshold
// boundaries, extreme ratios and empty events, then random events run under
// several thresholds, some long enough to saturate the event count
// ---------------------------------------------------------------------------
module charge_division_position_filter_tb;

	localparam int NUM_DETECTORS = cdpf_pkg::NUM_DETECTORS_DEF;
	localparam int HALF_PERIOD = 10;

	logic clk = 1'b0;
	logic arst_n;
	logic quiet = 1'b0;
	logic [cdpf_pkg::CHARGE_W-1:0] threshold_now = cdpf_pkg::THRESHOLD_RESET;
	int failures;
	int outstanding;
	int results_seen;
	int accepted_seen;
	int items_sent = 0;
	int events_sent = 0;
	int settings_used = 1;

	cdpf_in_if  det_if ();
	cdpf_out_if res_if ();
	cdpf_cfg_if cfg_if ();

	charge_division_position_filter #(
		.NUM_DETECTORS(NUM_DETECTORS)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.det_in (det_if),
		.res_out(res_if),
		.cfg    (cfg_if)
	);

	cdpf_checker #(
		.NUM_DETECTORS(NUM_DETECTORS)
	) position_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.det          (det_if),
		.res          (res_if),
		.cfg          (cfg_if),
		.failures     (failures),
		.outstanding  (outstanding),
		.results_seen (results_seen),
		.accepted_seen(accepted_seen)
	);

	always #(HALF_PERIOD) clk = ~clk;

	initial begin
		#(20_000_000);
		$display("** charge_division_position_filter: FAILED **");
		$finish;
	end

	// result side back-pressure
	initial begin
		res_if.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		res_if.ready = 1'b1;
		forever begin
			repeat ($urandom_range(1, 40)) @(negedge clk);
			if (!quiet && $urandom_range(0, 2) != 0) begin
				res_if.ready = 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				res_if.ready = 1'b1;
			end
		end
	end

	// called at a falling edge, returns at the falling edge after the handshake
	task automatic send_detector(
		input logic [cdpf_pkg::DET_W-1:0]    idx,
		input logic [cdpf_pkg::CHARGE_W-1:0] x1,
		input logic [cdpf_pkg::CHARGE_W-1:0] x2,
		input logic [cdpf_pkg::CHARGE_W-1:0] z1,
		input logic [cdpf_pkg::CHARGE_W-1:0] z2,
		input logic                          last
	);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			det_if.valid = 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		det_if.detector_index = idx;
		det_if.charge_x_first = x1;
		det_if.charge_x_second = x2;
		det_if.charge_z_first = z1;
		det_if.charge_z_second = z2;
		det_if.event_last = last;
		det_if.valid = 1'b1;
		@(posedge clk);
		while (!det_if.ready) @(posedge clk);
		@(negedge clk);
		items_sent++;
		if (last) begin
			events_sent++;
		end
	endtask

	// only once the block has drained
	task automatic write_threshold(input logic [cdpf_pkg::CHARGE_W-1:0] value);
		det_if.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_if.charge_threshold = value;
		cfg_if.valid = 1'b1;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		@(negedge clk);
		cfg_if.valid = 1'b0;
		threshold_now = value;
		settings_used++;
	endtask

	function automatic logic [cdpf_pkg::CHARGE_W-1:0] charge_above(
		input logic [cdpf_pkg::CHARGE_W-1:0] thr
	);
		if (thr == '1) begin
			return '1;
		end
		return cdpf_pkg::CHARGE_W'($urandom_range(int'(thr) + 1, 4095));
	endfunction

	function automatic logic [cdpf_pkg::CHARGE_W-1:0] charge_any(
		input logic [cdpf_pkg::CHARGE_W-1:0] thr
	);
		int unsigned pick;
		pick = $urandom_range(0, 3);
		if (pick == 0) begin
			return thr;
		end else if (pick == 1) begin
			return thr + 1'b1;
		end
		return cdpf_pkg::CHARGE_W'($urandom_range(0, 4095));
	endfunction

	// one event of random length, mostly accepted detectors
	task automatic random_event(output int len);
		logic take;
		logic [cdpf_pkg::CHARGE_W-1:0] q[4];
		len = ($urandom_range(0, 11) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 6);
		for (int i = 0; i < len; i++) begin
			take = $urandom_range(0, 3) != 0;
			for (int k = 0; k < 4; k++) begin
				q[k] = take ? charge_above(threshold_now) : charge_any(threshold_now);
			end
			send_detector(cdpf_pkg::DET_W'($urandom_range(0, 15)), q[0], q[1], q[2], q[3],
				i == len - 1);
		end
	endtask

	initial begin
		logic [cdpf_pkg::CHARGE_W-1:0] phase_threshold[6];
		int phase_items[6];
		int done_items;
		int len;
		int w;

		arst_n = 1'b0;
		det_if.valid = 1'b0;
		det_if.detector_index = '0;
		det_if.charge_x_first = '0;
		det_if.charge_x_second = '0;
		det_if.charge_z_first = '0;
		det_if.charge_z_second = '0;
		det_if.event_last = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.charge_threshold = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// threshold at its reset value
		send_detector(4'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0);
		send_detector(4'd1, 12'd401, 12'd4095, 12'd4095, 12'd401, 1'b0);
		send_detector(4'd2, 12'd400, 12'd4095, 12'd4095, 12'd4095, 1'b0);
		send_detector(4'd3, 12'd4095, 12'd4095, 12'd4095, 12'd400, 1'b0);
		send_detector(4'd4, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
		send_detector(4'd15, 12'd1234, 12'd2345, 12'd3000, 12'd999, 1'b1);
		send_detector(4'd7, 12'd0, 12'd4095, 12'd0, 12'd4095, 1'b1);
		send_detector(4'd8, 12'd600, 12'd500, 12'd401, 12'd402, 1'b1);

		// threshold zero: smallest charges, largest ratios
		write_threshold(12'd0);
		send_detector(4'd0, 12'd1, 12'd4095, 12'd4095, 12'd1, 1'b0);
		send_detector(4'd1, 12'd4095, 12'd1, 12'd1, 12'd1, 1'b0);
		send_detector(4'd5, 12'hAAA, 12'h555, 12'h555, 12'hAAA, 1'b0);
		send_detector(4'd2, 12'd0, 12'd4095, 12'd4095, 12'd4095, 1'b0);
		send_detector(4'd3, 12'd1, 12'd2, 12'd4095, 12'd4094, 1'b1);

		// top thresholds: nothing passes, then only full scale
		write_threshold(12'd4095);
		send_detector(4'd9, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1);
		write_threshold(12'd4094);
		send_detector(4'd10, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0);
		send_detector(4'd11, 12'd4094, 12'd4095, 12'd4095, 12'd4095, 1'b1);

		phase_threshold = '{12'd400, 12'd0, cdpf_pkg::CHARGE_W'($urandom_range(1, 4094)),
			12'd4095, cdpf_pkg::CHARGE_W'($urandom_range(1, 1000)), 12'd400};
		phase_items = '{170, 170, 170, 40, 170, 170};
		for (int p = 0; p < 6; p++) begin
			write_threshold(phase_threshold[p]);
			quiet = (p == 5);
			done_items = 0;
			while (done_items < phase_items[p]) begin
				random_event(len);
				done_items += len;
			end
		end

		det_if.valid = 1'b0;
		for (w = 0; w < 20000 && outstanding != 0; w++) @(negedge clk);
		repeat (20) @(negedge clk);
		if (outstanding != 0) begin
			$error("%0d expected results never arrived", outstanding);
		end
		$display("sent %0d detector items in %0d events under %0d threshold settings",
			items_sent, events_sent, settings_used);
		$display("checked %0d results, %0d of them accepted detectors",
			results_seen, accepted_seen);
		if (failures == 0 && outstanding == 0) begin
			$display("** charge_division_position_filter: PASSED **");
		end else begin
			$display("** charge_division_position_filter: FAILED **");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/cdpf_pkg.sv
sv/cdpf_in_if.sv
sv/cdpf_out_if.sv
sv/cdpf_cfg_if.sv
sv/cdpf_datapath.sv
sv/cdpf_ctrl.sv
sv/charge_division_position_filter.sv
sv/cdpf_checker.sv
dv/cdpf_checker.sv
dv/charge_division_position_filter_tb.sv
